### src/plfd_pkg.sv
// Shared types and constants for the prefixed length field decoder.
package plfd_pkg;

  // Form codes reported with each decoded length
  typedef enum logic [1:0] {
    FORM_6BIT  = 2'd0,
    FORM_14BIT = 2'd1,
    FORM_32BIT = 2'd2,
    FORM_FIXED = 2'd3
  } plfd_form_e;

  // Two-bit prefix codes of the first byte in version 1
  localparam logic [1:0] PFX_6BIT  = 2'b00;
  localparam logic [1:0] PFX_14BIT = 2'b01;

  // Format versions
  localparam logic VER_FIXED    = 1'b0;
  localparam logic VER_PREFIXED = 1'b1;

  localparam logic [5:0] LOW6_MASK = 6'h3F;

  // Byte counts still needed after a first byte
  localparam logic [2:0] LEFT_FIXED = 3'd3;
  localparam logic [2:0] LEFT_14BIT = 3'd1;
  localparam logic [2:0] LEFT_32BIT = 3'd4;

  // One decode result between the step logic and the output register
  typedef struct packed {
    logic        valid;
    logic [31:0] length_value;
    plfd_form_e  field_form;
  } plfd_result_t;

endpackage

### src/plfd_in_if.sv
// Input and output channel interfaces of the prefixed length field decoder.
interface plfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface plfd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] length_value;
  logic [1:0]  field_form;

  modport source (output valid, output length_value, output field_form, input ready);
  modport sink (input valid, input length_value, input field_form, output ready);
endinterface

### src/plfd_decode.sv
// Field decode state and one-byte step logic.
module plfd_decode (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  input  logic                  version_i,
  output plfd_pkg::plfd_result_t result_o
);

  plfd_pkg::plfd_form_e mode_q, mode_d;
  logic [2:0]           left_q, left_d;
  logic [31:0]          part_q, part_d;
  logic [31:0]          shifted;

  assign shifted = {part_q[23:0], byte_i};

  // Next state and result for the byte at hand
  always_comb begin
    mode_d   = mode_q;
    left_d   = left_q;
    part_d   = part_q;
    result_o = '{valid: 1'b0, length_value: shifted, field_form: mode_q};
    if (left_q == 3'd0) begin
      if (version_i == plfd_pkg::VER_FIXED) begin
        mode_d = plfd_pkg::FORM_FIXED;
        part_d = {24'd0, byte_i};
        left_d = plfd_pkg::LEFT_FIXED;
      end else begin
        unique case (byte_i[7:6])
          plfd_pkg::PFX_6BIT: begin
            result_o.valid        = 1'b1;
            result_o.length_value = {26'd0, byte_i[5:0] & plfd_pkg::LOW6_MASK};
            result_o.field_form   = plfd_pkg::FORM_6BIT;
            mode_d                = plfd_pkg::FORM_6BIT;
            part_d                = '0;
          end
          plfd_pkg::PFX_14BIT: begin
            mode_d = plfd_pkg::FORM_14BIT;
            part_d = {26'd0, byte_i[5:0] & plfd_pkg::LOW6_MASK};
            left_d = plfd_pkg::LEFT_14BIT;
          end
          default: begin
            // prefixes 10 and 11 both mean four more bytes
            mode_d = plfd_pkg::FORM_32BIT;
            part_d = '0;
            left_d = plfd_pkg::LEFT_32BIT;
          end
        endcase
      end
    end else begin
      left_d = left_q - 3'd1;
      part_d = shifted;
      if (left_d == 3'd0) begin
        result_o.valid = 1'b1;
        mode_d         = plfd_pkg::FORM_6BIT;
        part_d         = '0;
      end
    end
    if (!step_i) begin
      result_o.valid = 1'b0;
    end
  end

  // Decode state, updated once per consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= plfd_pkg::FORM_6BIT;
      left_q <= 3'd0;
      part_q <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      left_q <= left_d;
      part_q <= part_d;
    end
  end

  // never more than four bytes outstanding
  a_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= plfd_pkg::LEFT_32BIT)
    else $error("bytes left out of range");

  // a fixed word never waits for more than three bytes
  a_fixed_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == plfd_pkg::FORM_FIXED) |-> (left_q <= plfd_pkg::LEFT_FIXED))
    else $error("fixed word with too many bytes left");

  // a completed field returns the decoder to waiting for a first byte
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |=> (left_q == 3'd0 && part_q == 32'd0))
    else $error("decoder not idle after a result");

endmodule

### src/prefixed_length_field_decoder.sv
// Top level of the prefixed length field decoder: input, config and result registers.
// Result path: a byte that completes a field drives its result on the output after it
// has passed the input register, then the result register.
// Throughput: one byte per cycle; the decode step is a single pass over the
// input register, so a byte enters every cycle the result register can move.
// Reset: asynchronous active low; clears decode state and valid flags, sets version 1.
module prefixed_length_field_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  plfd_in_if.sink     in_i,
  plfd_out_if.source  out_o
);

  logic                   version_q;
  logic                   s1_valid_q;
  logic [7:0]             s1_byte_q;
  logic                   out_valid_q;
  logic [31:0]            out_len_q;
  plfd_pkg::plfd_form_e   out_form_q;
  logic                   out_free;
  logic                   s1_step;
  plfd_pkg::plfd_result_t step_res;

  // Output register can take a new result when empty or draining
  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_step    = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= plfd_pkg::VER_PREFIXED;
    end else if (cfg_we_i) begin
      version_q <= cfg_wdata_i;
    end
  end

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.data_byte;
    end
  end

  plfd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (s1_step),
    .byte_i    (s1_byte_q),
    .version_i (version_q),
    .result_o  (step_res)
  );

  // Result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step_res.valid;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (out_free && step_res.valid) begin
      out_len_q  <= step_res.length_value;
      out_form_q <= step_res.field_form;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.length_value = out_len_q;
  assign out_o.field_form   = out_form_q;

  // a waiting result is never dropped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> out_valid_q)
    else $error("pending result lost");

  // a held byte is consumed whenever the result side can move
  a_s1_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_free && !in_i.valid) |=> !s1_valid_q)
    else $error("input register not drained");

  // a result only appears after a byte was stepped
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_step))
    else $error("result without a consumed byte");

endmodule

### sim/tb.sv
// Self-checking testbench for the prefixed length field decoder.
module tb;

  localparam int IdleLimit   = 4000;  // cycles without any transaction
  localparam int PhaseBytes  = 160;
  localparam int NumPhases   = 12;
  localparam int LongHold    = 400;
  localparam int MaxReported = 10;

  typedef struct {
    logic [31:0]          length_value;
    plfd_pkg::plfd_form_e field_form;
  } decoded_len_t;

  // Tracks the decode state of the stream and the lengths still owed by the block
  class length_decode_board;
    logic                 version;
    plfd_pkg::plfd_form_e cur_form;
    logic [2:0]           need;
    logic [31:0]          acc;
    decoded_len_t         expected_lengths[$];
    int                   errors;

    function new();
      version  = plfd_pkg::VER_PREFIXED;
      cur_form = plfd_pkg::FORM_6BIT;
      need     = '0;
      acc      = '0;
      errors   = 0;
    endfunction

    function void set_version(logic v);
      version = v;
    endfunction

    // Advance the decode by one accepted byte; queue a length when a field completes
    function void take_byte(logic [7:0] b);
      decoded_len_t d;
      if (need == 3'd0) begin
        // first byte of a field: version only matters here
        if (version == plfd_pkg::VER_FIXED) begin
          cur_form = plfd_pkg::FORM_FIXED;
          acc      = {24'd0, b};
          need     = plfd_pkg::LEFT_FIXED;
        end else begin
          case (b[7:6])
            plfd_pkg::PFX_6BIT: begin
              d.length_value = {26'd0, b[5:0] & plfd_pkg::LOW6_MASK};
              d.field_form   = plfd_pkg::FORM_6BIT;
              expected_lengths.push_back(d);
              cur_form = plfd_pkg::FORM_6BIT;
              acc      = '0;
            end
            plfd_pkg::PFX_14BIT: begin
              cur_form = plfd_pkg::FORM_14BIT;
              acc      = {26'd0, b[5:0] & plfd_pkg::LOW6_MASK};
              need     = plfd_pkg::LEFT_14BIT;
            end
            default: begin
              // prefixes 10 and 11 alike; low six bits dropped
              cur_form = plfd_pkg::FORM_32BIT;
              acc      = '0;
              need     = plfd_pkg::LEFT_32BIT;
            end
          endcase
        end
      end else begin
        acc  = {acc[23:0], b};
        need = need - 3'd1;
        if (need == 3'd0) begin
          d.length_value = acc;
          d.field_form   = cur_form;
          expected_lengths.push_back(d);
          cur_form = plfd_pkg::FORM_6BIT;
          acc      = '0;
        end
      end
    endfunction

    // Compare one delivered length with the oldest one owed
    function void match_length(logic [31:0] len, logic [1:0] form);
      decoded_len_t d;
      if (expected_lengths.size() == 0) begin
        errors++;
        if (errors <= MaxReported)
          $display("unexpected result: length %0h form %0d", len, form);
        return;
      end
      d = expected_lengths.pop_front();
      if (len !== d.length_value || form !== d.field_form) begin
        errors++;
        if (errors <= MaxReported)
          $display("mismatch: exp length %0h form %0d, got length %0h form %0d",
                   d.length_value, d.field_form, len, form);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  plfd_in_if  in_ch ();
  plfd_out_if out_ch ();

  prefixed_length_field_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  length_decode_board sb;
  logic [7:0] stream_q[$];
  bit  tx_no_gap;
  bit  rx_no_gap;
  bit  rx_fast;
  int  hold_cycles;
  int  idle_cnt;

  // Clock and initial drive
  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'd0;
    out_ch.ready    = 1'b0;
    tx_no_gap       = 1'b0;
    rx_no_gap       = 1'b0;
    rx_fast         = 1'b0;
    hold_cycles     = 0;
    idle_cnt        = 0;
    sb              = new();
  end

  always #6 clk = ~clk;

  // Transaction monitors and idle watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.take_byte(in_ch.data_byte);
      if (out_ch.valid && out_ch.ready)
        sb.match_length(out_ch.length_value, out_ch.field_form);
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cnt = 0;
    else
      idle_cnt++;
    if (idle_cnt >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result sink: random stalls, optional long hold-off
  initial begin
    int n;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else if (rx_fast || rx_no_gap) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 19);
      end
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Offer one byte after a random gap and wait for its transaction
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_no_gap ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  // Wait until every owed length has arrived and the block has settled
  task automatic drain();
    int run;
    in_ch.valid <= 1'b0;
    rx_fast = 1'b1;
    while (sb.expected_lengths.size() != 0) @(posedge clk);
    run = 0;
    while (run < 6) begin
      @(posedge clk);
      run = out_ch.ready ? run + 1 : 0;
    end
    rx_fast = 1'b0;
  endtask

  task automatic send_stream();
    while (stream_q.size() != 0) send_byte(stream_q.pop_front());
    drain();
  endtask

  task automatic write_version(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    sb.set_version(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Append one well-formed field with random content for the given version
  function automatic void add_field(logic v);
    logic [31:0] w;
    int unsigned kind;
    kind = $urandom_range(0, 7);
    w = (kind == 0) ? 32'hFFFF_FFFF : (kind == 1) ? 32'd0 : $urandom;
    if (v == plfd_pkg::VER_FIXED) begin
      stream_q.push_back(w[31:24]);
      stream_q.push_back(w[23:16]);
      stream_q.push_back(w[15:8]);
      stream_q.push_back(w[7:0]);
    end else begin
      case ($urandom_range(0, 3))
        0: stream_q.push_back({plfd_pkg::PFX_6BIT, w[5:0]});
        1: begin
          stream_q.push_back({plfd_pkg::PFX_14BIT, w[13:8]});
          stream_q.push_back(w[7:0]);
        end
        default: begin
          stream_q.push_back({1'b1, 1'($urandom_range(0, 1)), 6'($urandom)});
          stream_q.push_back(w[31:24]);
          stream_q.push_back(w[23:16]);
          stream_q.push_back(w[15:8]);
          stream_q.push_back(w[7:0]);
        end
      endcase
    end
  endfunction

  // Main sequence
  initial begin
    logic v;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: six-bit min/max, fourteen-bit min/max, prefix 11 with all-ones
    // length and stray low bits, then a 32-bit field left open
    stream_q = '{8'h00, 8'h3F, 8'h40, 8'h00, 8'h7F, 8'hFF,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hC1, 8'hAA};
    send_stream();
    // Version change mid-field: open field keeps its 32-bit form
    write_version(plfd_pkg::VER_FIXED);
    stream_q = '{8'hBB, 8'hCC, 8'hDD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h12, 8'h34};
    send_stream();
    // Back to prefixed while a fixed word is half done
    write_version(plfd_pkg::VER_PREFIXED);
    stream_q = '{8'h56, 8'h78};
    send_stream();

    // Random phases; a phase may end mid-field, so version switches hit open fields
    for (int ph = 0; ph < NumPhases; ph++) begin
      v = (ph == 0) ? plfd_pkg::VER_FIXED :
          (ph == 1) ? plfd_pkg::VER_PREFIXED : 1'($urandom_range(0, 1));
      write_version(v);
      tx_no_gap = ($urandom_range(0, 3) == 0);
      rx_no_gap = ($urandom_range(0, 3) == 0);
      if (ph == 3) begin
        // receiver holds off while bytes keep coming
        tx_no_gap   = 1'b1;
        hold_cycles = LongHold;
      end
      while (stream_q.size() < PhaseBytes) add_field(v);
      while (stream_q.size() > PhaseBytes) void'(stream_q.pop_back());
      send_stream();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_lengths.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
